@@ sv/fastq_record_parser_defines.svh @@
// ----------------------------------------------------------------------------
// FASTQ record parser assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FASTQ_RECORD_PARSER_DEFINES_SVH
`define FASTQ_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define FQP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FQP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FQP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FQP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/fqp_pkg.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser package
// Shared types, character codes, error and field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fqp_pkg;

  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_AT   = 8'd64;
  localparam logic [7:0] CH_PLUS = 8'd43;

  localparam logic [1:0] FLD_NONE = 2'd0;
  localparam logic [1:0] FLD_HDR  = 2'd1;
  localparam logic [1:0] FLD_SEQ  = 2'd2;
  localparam logic [1:0] FLD_QUAL = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_AT     = 3'd1;
  localparam logic [2:0] ERR_UNEXP_END = 3'd2;
  localparam logic [2:0] ERR_ILL_SEQ   = 3'd3;
  localparam logic [2:0] ERR_PLUS_MM   = 3'd4;
  localparam logic [2:0] ERR_ILL_QUAL  = 3'd5;
  localparam logic [2:0] ERR_LEN_MM    = 3'd6;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_SEQ    = 5'b00100,
    PH_PLUS   = 5'b01000,
    PH_QUAL   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } item_t;

  typedef struct packed {
    logic       out_valid;
    logic [1:0] out_field;
    logic [7:0] out_byte;
    logic       record_done;
    logic [2:0] error_code;
    logic       stream_done;
  } result_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
  endfunction

  function automatic logic is_iupac(input logic [7:0] b);
    logic [7:0] u;
    u = to_upper(b);
    case (u) inside
      "A", "C", "G", "T", "U", "R", "Y", "S",
      "W", "K", "M", "B", "D", "H", "V", "N": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ sv/fqp_in_if.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser input channel
// Valid/ready channel carrying one stream byte or the end-of-stream mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface fqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

@@ sv/fqp_out_if.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser result channel
// Valid/ready channel carrying one parse result per input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fqp_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [1:0] out_field;
  logic [7:0] out_byte;
  logic       record_done;
  logic [2:0] error_code;
  logic       stream_done;

  modport source (output valid, output out_valid, output out_field, output out_byte,
                  output record_done, output error_code, output stream_done,
                  input ready);
  modport sink   (input valid, input out_valid, input out_field, input out_byte,
                  input record_done, input error_code, input stream_done,
                  output ready);
endinterface

`default_nettype wire

@@ sv/fqp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser configuration channel
// Valid/ready write channel for the upcase enable register.
// ----------------------------------------------------------------------------
`default_nettype none

interface fqp_cfg_if;
  logic valid;
  logic ready;
  logic upcase_enable;

  modport source (output valid, output upcase_enable, input ready);
  modport sink   (input valid, input upcase_enable, output ready);
endinterface

`default_nettype wire

@@ sv/fastq_record_parser.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser
// Checks FASTQ record structure byte by byte and emits kept symbols.
// ----------------------------------------------------------------------------
// Path: input register, then parse logic into the result register.
// Throughput: one byte per cycle while the result register can load,
//   set by the single-pass phase update.
// Reset: synchronous rst_n clears phase, counters, error latch and
//   upcase_enable; the header store is not cleared.
`default_nettype none

module fastq_record_parser #(
  parameter int MAX_HEADER = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fqp_in_if.sink    in_if,
  fqp_cfg_if.sink   cfg_if,
  fqp_out_if.source out_if
);
  import fqp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    fire;
  result_t res;
  result_t out_res;

  assign in_item.data = in_if.in_byte;
  assign in_item.eos  = in_if.end_of_stream;
  assign fire         = item_valid && can_load;
  assign cfg_if.ready = 1'b1;

  fqp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (fire)
  );

  fqp_parse #(
    .MAX_HEADER (MAX_HEADER),
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_if.valid),
    .cfg_upcase (cfg_if.upcase_enable),
    .fire       (fire),
    .item       (item),
    .res        (res)
  );

  fqp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (fire),
    .res      (res),
    .can_load (can_load),
    .out_vld  (out_if.valid),
    .out_res  (out_res),
    .out_rdy  (out_if.ready)
  );

  assign out_if.out_valid   = out_res.out_valid;
  assign out_if.out_field   = out_res.out_field;
  assign out_if.out_byte    = out_res.out_byte;
  assign out_if.record_done = out_res.record_done;
  assign out_if.error_code  = out_res.error_code;
  assign out_if.stream_done = out_res.stream_done;
endmodule

`default_nettype wire

@@ sv/fqp_in_stage.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser input register
// Holds one accepted input transaction until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fqp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fqp_pkg::item_t in_item,
  output logic               item_valid,
  output fqp_pkg::item_t     item,
  input  wire logic          item_take
);
  import fqp_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_ready   = !vld_r || item_take;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (item_take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end
endmodule

`default_nettype wire

@@ sv/fqp_parse.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser state machine
// Record phase tracking, header store, plus line check and counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fastq_record_parser_defines.svh"

module fqp_parse #(
  parameter int MAX_HEADER = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_upcase,
  input  wire logic           fire,
  input  wire fqp_pkg::item_t item,
  output fqp_pkg::result_t    res
);
  import fqp_pkg::*;

  localparam int HA = $clog2(MAX_HEADER);
  localparam int LW = $clog2(MAX_HEADER + 2);
  localparam logic [LW-1:0] MAX_L  = LW'(MAX_HEADER);
  localparam logic [LW-1:0] MAX_P1 = LW'(MAX_HEADER + 1);

  logic [7:0] hdr_mem [MAX_HEADER];
  logic [7:0] rd_data_r;

  logic                  upcase_r;
  phase_t                phase_r, phase_nxt;
  logic                  ls_r, ls_nxt;
  logic [COUNT_BITS-1:0] seq_cnt_r, seq_cnt_nxt;
  logic [COUNT_BITS-1:0] qual_cnt_r, qual_cnt_nxt;
  logic [LW-1:0]         hdr_len_r, hdr_len_nxt;
  logic                  hdr_ovf_r, hdr_ovf_nxt;
  logic [LW-1:0]         plus_len_r, plus_len_nxt;
  logic                  plus_diff_r, plus_diff_nxt;
  logic                  plus_cr_r, plus_cr_nxt;
  logic                  err_r, err_nxt;

  logic                  mem_we;
  logic [HA-1:0]         rd_addr;
  logic                  take_diff;
  logic                  take_cr;
  logic [LW-1:0]         take_len;
  logic                  empty_ok;
  logic                  start_rec;
  logic                  cnt_eq;
  logic [7:0]            d;

  assign d      = item.data;
  assign cnt_eq = (qual_cnt_r == seq_cnt_r);

  assign take_diff = plus_diff_r || hdr_ovf_r || (plus_len_r >= hdr_len_r) ||
                     (plus_len_r >= MAX_L) || (rd_data_r != d);
  assign take_cr   = plus_cr_r || ((plus_len_r == '0) && (d == CH_CR));
  assign take_len  = (plus_len_r < MAX_P1) ? plus_len_r + 1'b1 : plus_len_r;
  assign empty_ok  = (plus_len_r == '0) || ((plus_len_r == LW'(1)) && plus_cr_r);

  always_comb begin
    phase_nxt     = phase_r;
    ls_nxt        = ls_r;
    seq_cnt_nxt   = seq_cnt_r;
    qual_cnt_nxt  = qual_cnt_r;
    hdr_len_nxt   = hdr_len_r;
    hdr_ovf_nxt   = hdr_ovf_r;
    plus_len_nxt  = plus_len_r;
    plus_diff_nxt = plus_diff_r;
    plus_cr_nxt   = plus_cr_r;
    err_nxt       = err_r;
    mem_we        = 1'b0;
    start_rec     = 1'b0;
    res           = '0;

    if (fire && !err_r) begin
      unique case (phase_r)
        PH_START: begin
          if (item.eos) begin
            res.stream_done = 1'b1;
          end else if (d == CH_AT) begin
            start_rec = 1'b1;
          end else begin
            res.error_code = ERR_NO_AT;
          end
        end
        PH_HEADER: begin
          if (item.eos) begin
            res.error_code = ERR_UNEXP_END;
          end else begin
            if (hdr_len_r < MAX_L) begin
              mem_we      = 1'b1;
              hdr_len_nxt = hdr_len_r + 1'b1;
            end else begin
              hdr_ovf_nxt = 1'b1;
            end
            if (d == CH_LF) begin
              phase_nxt = PH_SEQ;
              ls_nxt    = 1'b0;
            end else begin
              res.out_valid = 1'b1;
              res.out_field = FLD_HDR;
              res.out_byte  = d;
            end
          end
        end
        PH_SEQ: begin
          if (item.eos) begin
            res.error_code = ERR_UNEXP_END;
          end else if (ls_r && d == CH_PLUS) begin
            phase_nxt = PH_PLUS;
          end else if (d == CH_LF) begin
            ls_nxt = 1'b1;
          end else begin
            ls_nxt = 1'b0;
            if (d != CH_CR) begin
              if (is_iupac(d)) begin
                res.out_valid = 1'b1;
                res.out_field = FLD_SEQ;
                res.out_byte  = upcase_r ? to_upper(d) : d;
                seq_cnt_nxt   = (seq_cnt_r == '1) ? seq_cnt_r : seq_cnt_r + 1'b1;
              end else begin
                res.error_code = ERR_ILL_SEQ;
                res.out_byte   = d;
              end
            end
          end
        end
        PH_PLUS: begin
          if (item.eos) begin
            res.error_code = ERR_UNEXP_END;
          end else begin
            plus_diff_nxt = take_diff;
            plus_cr_nxt   = take_cr;
            plus_len_nxt  = take_len;
            if (d == CH_LF) begin
              if (take_diff && !empty_ok) begin
                res.error_code = ERR_PLUS_MM;
              end else begin
                phase_nxt = PH_QUAL;
                ls_nxt    = 1'b0;
              end
            end else if (take_diff && !((take_len == LW'(1)) && take_cr)) begin
              res.error_code = ERR_PLUS_MM;
            end
          end
        end
        PH_QUAL: begin
          if (item.eos) begin
            if (cnt_eq) begin
              res.record_done = 1'b1;
              res.stream_done = 1'b1;
              phase_nxt       = PH_START;
            end else begin
              res.error_code = ERR_LEN_MM;
            end
          end else if (ls_r && d == CH_AT && cnt_eq) begin
            res.record_done = 1'b1;
            start_rec       = 1'b1;
          end else if (d == CH_LF) begin
            if (qual_cnt_r > seq_cnt_r) begin
              res.error_code = ERR_LEN_MM;
            end else begin
              ls_nxt = 1'b1;
            end
          end else begin
            ls_nxt = 1'b0;
            if (d != CH_CR) begin
              if (d >= 8'd33 && d <= 8'd126) begin
                res.out_valid = 1'b1;
                res.out_field = FLD_QUAL;
                res.out_byte  = d;
                qual_cnt_nxt  = (qual_cnt_r == '1) ? qual_cnt_r : qual_cnt_r + 1'b1;
              end else begin
                res.error_code = ERR_ILL_QUAL;
                res.out_byte   = d;
              end
            end
          end
        end
        default: ;
      endcase

      if (start_rec) begin
        phase_nxt     = PH_HEADER;
        ls_nxt        = 1'b0;
        seq_cnt_nxt   = '0;
        qual_cnt_nxt  = '0;
        hdr_len_nxt   = '0;
        hdr_ovf_nxt   = 1'b0;
        plus_len_nxt  = '0;
        plus_diff_nxt = 1'b0;
        plus_cr_nxt   = 1'b0;
      end
      if (res.error_code != ERR_NONE) begin
        err_nxt = 1'b1;
      end
    end
  end

  // prefetch the header byte that the next plus line byte is compared to
  assign rd_addr = (plus_len_nxt < MAX_L) ? plus_len_nxt[HA-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[hdr_len_r[HA-1:0]] <= d;
    end
    rd_data_r <= hdr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upcase_r    <= 1'b0;
      phase_r     <= PH_START;
      ls_r        <= 1'b0;
      seq_cnt_r   <= '0;
      qual_cnt_r  <= '0;
      hdr_len_r   <= '0;
      hdr_ovf_r   <= 1'b0;
      plus_len_r  <= '0;
      plus_diff_r <= 1'b0;
      plus_cr_r   <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        upcase_r <= cfg_upcase;
      end
      phase_r     <= phase_nxt;
      ls_r        <= ls_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      qual_cnt_r  <= qual_cnt_nxt;
      hdr_len_r   <= hdr_len_nxt;
      hdr_ovf_r   <= hdr_ovf_nxt;
      plus_len_r  <= plus_len_nxt;
      plus_diff_r <= plus_diff_nxt;
      plus_cr_r   <= plus_cr_nxt;
      err_r       <= err_nxt;
    end
  end

  `FQP_ASSERT(a_err_sticky, clk, rst_n, err_r |=> err_r, "error latch cleared without reset")
  `FQP_ASSERT(a_silent_after_err, clk, rst_n, (fire && err_r) |-> (res == '0), "output after error")
  `FQP_ASSERT(a_hdr_len_bound, clk, rst_n, hdr_len_r <= MAX_L, "header length beyond store")
endmodule

`default_nettype wire

@@ sv/fqp_out_stage.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fastq_record_parser_defines.svh"

module fqp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_load,
  input  wire fqp_pkg::result_t res,
  output logic                  can_load,
  output logic                  out_vld,
  output fqp_pkg::result_t      out_res,
  input  wire logic             out_rdy
);
  import fqp_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign can_load = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_load) begin
      vld_r <= 1'b1;
    end else if (out_rdy) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  `FQP_ASSERT_ALWAYS(a_out_reset, clk, !rst_n |=> !vld_r, "result valid after reset")
endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// FASTQ record parser testbench
// Drives FASTQ byte streams of random and directed records through the parser
// (with random source and sink stalls in the first two phases) and checks every
// result transaction against a cycle-free parse of the same bytes. Each run ends
// with one randomly chosen malformed record, since an error stays latched until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import fqp_pkg::*;

  localparam int MAX_HDR       = 256;
  localparam int CNT_BITS      = 24;
  localparam int PHASE_ITEMS   = 320;
  localparam int SETTLE_CYCLES = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fqp_in_if  in_if ();
  fqp_cfg_if cfg_if ();
  fqp_out_if out_if ();

  fastq_record_parser #(
    .MAX_HEADER(MAX_HDR),
    .COUNT_BITS(CNT_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .cfg_if(cfg_if),
    .out_if(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stream state of the parse
  phase_t              pstate        = PH_START;
  logic                line_start    = 1'b0;
  logic [CNT_BITS-1:0] seq_cnt       = '0;
  logic [CNT_BITS-1:0] qual_cnt      = '0;
  logic [7:0]          hdr_mem [MAX_HDR];
  logic [8:0]          hdr_len       = '0;
  logic                hdr_over      = 1'b0;
  logic [8:0]          plus_len      = '0;
  logic                plus_bad      = 1'b0;
  logic                plus_cr_first = 1'b0;
  logic                halted        = 1'b0;
  logic                upcase_on     = 1'b0;

  string   nuc_codes = "ACGTURYSWKMBDHVN";
  item_t   byte_stream [$];
  result_t parse_results [$];
  item_t   nxt;
  logic    in_taken   = 1'b0;
  int      src_idle   = 0;
  int      snk_idle   = 0;
  int      n_queued   = 0;
  int      n_accepted = 0;
  int      n_results  = 0;
  int      fail_count = 0;

  function automatic bit nucleotide_letter(logic [7:0] b);
    logic [7:0] u;
    u = (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
    for (int i = 0; i < nuc_codes.len(); i++) begin
      if (nuc_codes[i] == u) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void open_record();
    pstate        = PH_HEADER;
    line_start    = 1'b0;
    seq_cnt       = '0;
    qual_cnt      = '0;
    hdr_len       = '0;
    hdr_over      = 1'b0;
    plus_len      = '0;
    plus_bad      = 1'b0;
    plus_cr_first = 1'b0;
  endfunction

  function automatic result_t parse_fastq_byte(logic [7:0] b, logic eos);
    result_t r;
    logic    empty_ok;
    r = '0;
    if (!halted) begin
      case (pstate)
        PH_START: begin
          if (eos) r.stream_done = 1'b1;
          else if (b == CH_AT) open_record();
          else r.error_code = ERR_NO_AT;
        end
        PH_HEADER: begin
          if (eos) begin
            r.error_code = ERR_UNEXP_END;
          end else begin
            if (hdr_len < MAX_HDR) begin
              hdr_mem[hdr_len[7:0]] = b;
              hdr_len++;
            end else begin
              hdr_over = 1'b1;
            end
            if (b == CH_LF) begin
              pstate     = PH_SEQ;
              line_start = 1'b0;
            end else begin
              r.out_valid = 1'b1;
              r.out_field = FLD_HDR;
              r.out_byte  = b;
            end
          end
        end
        PH_SEQ: begin
          if (eos) begin
            r.error_code = ERR_UNEXP_END;
          end else if (line_start && b == CH_PLUS) begin
            pstate = PH_PLUS;
          end else if (b == CH_LF) begin
            line_start = 1'b1;
          end else begin
            line_start = 1'b0;
            if (b != CH_CR) begin
              if (nucleotide_letter(b)) begin
                r.out_valid = 1'b1;
                r.out_field = FLD_SEQ;
                r.out_byte  = (upcase_on && b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
                if (seq_cnt != '1) seq_cnt++;
              end else begin
                r.error_code = ERR_ILL_SEQ;
                r.out_byte   = b;
              end
            end
          end
        end
        PH_PLUS: begin
          if (eos) begin
            r.error_code = ERR_UNEXP_END;
          end else begin
            empty_ok = (plus_len == 0) || (plus_len == 1 && plus_cr_first);
            if (hdr_over || plus_len >= hdr_len || hdr_mem[plus_len[7:0]] != b)
              plus_bad = 1'b1;
            if (plus_len == 0 && b == CH_CR) plus_cr_first = 1'b1;
            if (plus_len < MAX_HDR + 1) plus_len++;
            if (b == CH_LF) begin
              if (plus_bad && !empty_ok) begin
                r.error_code = ERR_PLUS_MM;
              end else begin
                pstate     = PH_QUAL;
                line_start = 1'b0;
              end
            end else if (plus_bad && !(plus_len == 1 && plus_cr_first)) begin
              r.error_code = ERR_PLUS_MM;
            end
          end
        end
        default: begin
          if (eos) begin
            if (qual_cnt == seq_cnt) begin
              r.record_done = 1'b1;
              r.stream_done = 1'b1;
              pstate        = PH_START;
            end else begin
              r.error_code = ERR_LEN_MM;
            end
          end else if (line_start && b == CH_AT && qual_cnt == seq_cnt) begin
            r.record_done = 1'b1;
            open_record();
          end else if (b == CH_LF) begin
            if (qual_cnt > seq_cnt) r.error_code = ERR_LEN_MM;
            else line_start = 1'b1;
          end else begin
            line_start = 1'b0;
            if (b != CH_CR) begin
              if (b >= 8'd33 && b <= 8'd126) begin
                r.out_valid = 1'b1;
                r.out_field = FLD_QUAL;
                r.out_byte  = b;
                if (qual_cnt != '1) qual_cnt++;
              end else begin
                r.error_code = ERR_ILL_QUAL;
                r.out_byte   = b;
              end
            end
          end
        end
      endcase
      if (r.error_code != ERR_NONE) halted = 1'b1;
    end
    return r;
  endfunction

  task automatic note_failure(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d %s got %0h want %0h", n_results, name, got, want));
  endtask

  // ---------------- stimulus building ----------------

  task automatic push_byte(logic [7:0] b);
    item_t it;
    it.data = b;
    it.eos  = 1'b0;
    byte_stream.push_back(it);
    n_queued++;
  endtask

  task automatic push_eos();
    item_t it;
    it.data = 8'($urandom_range(255));
    it.eos  = 1'b1;
    byte_stream.push_back(it);
    n_queued++;
  endtask

  task automatic push_line_end();
    if ($urandom_range(3) == 0) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic add_record(int hdr_n, int seq_n);
    logic [7:0] hdr [$];
    logic [7:0] c;
    int         left;
    int         run;
    push_byte(CH_AT);
    repeat (hdr_n) begin
      do c = 8'($urandom_range(255)); while (c == CH_LF);
      hdr.push_back(c);
      push_byte(c);
    end
    push_byte(CH_LF);
    if (seq_n == 0) push_line_end();
    left = seq_n;
    while (left > 0) begin
      run = $urandom_range(1, (left < 20) ? left : 20);
      repeat (run) begin
        c = nuc_codes[$urandom_range(15)];
        if ($urandom_range(1)) c = c | 8'h20;
        push_byte(c);
        if ($urandom_range(24) == 0) push_byte(CH_CR);
      end
      left -= run;
      push_line_end();
      if ($urandom_range(15) == 0) push_byte(CH_LF);
    end
    push_byte(CH_PLUS);
    case ($urandom_range(2))
      0: ;
      1: push_byte(CH_CR);
      default: begin
        if (hdr_n < MAX_HDR) foreach (hdr[i]) push_byte(hdr[i]);
      end
    endcase
    push_byte(CH_LF);
    if (seq_n == 0) push_line_end();
    left = seq_n;
    while (left > 0) begin
      run = $urandom_range(1, (left < 20) ? left : 20);
      repeat (run) begin
        push_byte(($urandom_range(9) == 0) ? CH_AT : 8'($urandom_range(33, 126)));
        if ($urandom_range(24) == 0) push_byte(CH_CR);
      end
      left -= run;
      push_line_end();
      if ($urandom_range(15) == 0) push_byte(CH_LF);
    end
  endtask

  task automatic add_stream();
    int hdr_n;
    int seq_n;
    int pick;
    if ($urandom_range(9) == 0) begin
      push_eos();
    end else begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(99);
        if (pick < 90) hdr_n = $urandom_range(0, 12);
        else if (pick < 97) hdr_n = $urandom_range(13, 60);
        else if (pick == 97) hdr_n = MAX_HDR - 1;
        else if (pick == 98) hdr_n = MAX_HDR;
        else hdr_n = $urandom_range(MAX_HDR + 1, MAX_HDR + 44);
        pick = $urandom_range(99);
        if (pick < 8) seq_n = 0;
        else if (pick < 90) seq_n = $urandom_range(1, 30);
        else seq_n = $urandom_range(31, 120);
        add_record(hdr_n, seq_n);
      end
      push_eos();
    end
  endtask

  task automatic add_directed();
    // empty stream
    push_eos();
    // header with extreme bytes and CR, plus line repeating it, a lower and an upper case base
    push_byte(CH_AT); push_byte(8'h00); push_byte(8'hFF); push_byte(CH_CR); push_byte(CH_LF);
    push_byte("a"); push_byte("N"); push_byte(CH_LF);
    push_byte(CH_PLUS); push_byte(8'h00); push_byte(8'hFF); push_byte(CH_CR); push_byte(CH_LF);
    push_byte("!"); push_byte("~"); push_byte(CH_LF);
    // empty record: blank sequence line, CR LF plus line, blank quality, end
    push_byte(CH_AT); push_byte(CH_LF); push_byte(CH_LF);
    push_byte(CH_PLUS); push_byte(CH_CR); push_byte(CH_LF); push_byte(CH_LF);
    push_eos();
  endtask

  task automatic add_error_tail();
    logic [7:0] hdr [3];
    logic [7:0] c;
    int         k;
    case ($urandom_range(9))
      0: begin
        do c = 8'($urandom_range(255)); while (c == CH_AT);
        push_byte(c);
      end
      1: begin
        push_byte(CH_AT); push_byte("h"); push_eos();
      end
      2: begin
        push_byte(CH_AT); push_byte(CH_LF); push_byte("A"); push_eos();
      end
      3: begin
        push_byte(CH_AT); push_byte(CH_LF); push_byte("A"); push_byte(CH_LF);
        push_byte(CH_PLUS); push_eos();
      end
      4: begin
        push_byte(CH_AT); push_byte(CH_LF); push_byte("g");
        do c = 8'($urandom_range(255));
        while (nucleotide_letter(c) || c == CH_LF || c == CH_CR);
        push_byte(c);
      end
      5: begin
        // plus directly after the header line
        push_byte(CH_AT); push_byte("r"); push_byte(CH_LF); push_byte(CH_PLUS);
      end
      6: begin
        push_byte(CH_AT);
        foreach (hdr[i]) begin
          do hdr[i] = 8'($urandom_range(255)); while (hdr[i] == CH_LF);
          push_byte(hdr[i]);
        end
        push_byte(CH_LF); push_byte("C"); push_byte(CH_LF); push_byte(CH_PLUS);
        k = $urandom_range(2);
        for (int i = 0; i < k; i++) push_byte(hdr[i]);
        do c = 8'($urandom_range(255));
        while (c == hdr[k] || c == CH_LF || (k == 0 && c == CH_CR));
        push_byte(c);
      end
      7: begin
        push_byte(CH_AT); push_byte(CH_LF); push_byte("A"); push_byte(CH_LF);
        push_byte(CH_PLUS); push_byte(CH_LF);
        do c = 8'($urandom_range(255));
        while ((c >= 8'd33 && c <= 8'd126) || c == CH_LF || c == CH_CR);
        push_byte(c);
      end
      8: begin
        // quality line longer than the sequence
        push_byte(CH_AT); push_byte(CH_LF); push_byte("A"); push_byte("C"); push_byte(CH_LF);
        push_byte(CH_PLUS); push_byte(CH_LF);
        push_byte("!"); push_byte("#"); push_byte("%"); push_byte(CH_LF);
      end
      default: begin
        // stream ends with quality shorter than sequence
        push_byte(CH_AT); push_byte(CH_LF); push_byte("A"); push_byte("C"); push_byte("G");
        push_byte(CH_LF); push_byte(CH_PLUS); push_byte(CH_LF);
        push_byte("I"); push_byte("I"); push_eos();
      end
    endcase
    // block must stay silent from here on
    repeat ($urandom_range(8, 20)) begin
      if ($urandom_range(7) == 0) push_eos();
      else push_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic cfg_write(logic v);
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.upcase_enable <= v;
    do @(posedge clk); while (!cfg_if.ready);
    upcase_on = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || parse_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------- driver and monitor ----------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (byte_stream.size() != 0 && $urandom_range(99) >= src_idle) begin
        nxt = byte_stream.pop_front();
        in_if.valid         <= 1'b1;
        in_if.in_byte       <= nxt.data;
        in_if.end_of_stream <= nxt.eos;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        parse_results.push_back(parse_fastq_byte(in_if.in_byte, in_if.end_of_stream));
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (parse_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no transaction pending", n_results));
        end else begin
          want = parse_results.pop_front();
          check_field("out_valid", 8'(out_if.out_valid), 8'(want.out_valid));
          check_field("out_field", 8'(out_if.out_field), 8'(want.out_field));
          check_field("out_byte", out_if.out_byte, want.out_byte);
          check_field("record_done", 8'(out_if.record_done), 8'(want.record_done));
          check_field("error_code", 8'(out_if.error_code), 8'(want.error_code));
          check_field("stream_done", 8'(out_if.stream_done), 8'(want.stream_done));
        end
        n_results++;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin : stimulus
    int ph;
    int phase_base;
    in_if.valid          = 1'b0;
    in_if.in_byte        = '0;
    in_if.end_of_stream  = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.upcase_enable = 1'b0;
    out_if.ready         = 1'b0;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle = 27;
          snk_idle = 52;
          cfg_write(1'b1);
        end
        1: begin
          src_idle = 52;
          snk_idle = 27;
          cfg_write(1'b0);
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
          cfg_write(1'($urandom_range(1)));
        end
      endcase
      if (ph == 0) add_directed();
      phase_base = n_queued;
      while (n_queued - phase_base < PHASE_ITEMS) add_stream();
      if (ph == 2) add_error_tail();
      wait_drained();
    end

    if (fail_count == 0 && parse_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/fqp_pkg.sv
sv/fqp_in_if.sv
sv/fqp_out_if.sv
sv/fqp_cfg_if.sv
sv/fqp_in_stage.sv
sv/fqp_parse.sv
sv/fqp_out_stage.sv
sv/fastq_record_parser.sv
tb/tb_top.sv
